@@ rtl/tpf_pkg.sv @@
// Shared constants and types for the tachometer period-to-frequency meter.
package tpf_pkg;

  // Capture counter and derived tick count widths
  localparam int CNT_BITS   = 16;
  localparam int OVF_BITS   = 8;
  localparam int TICK_W     = CNT_BITS + OVF_BITS;

  // Register widths
  localparam int RATE_W     = 24;
  localparam int FREQ_W     = 16;
  localparam int FACT_W     = 8;
  localparam int RPM_W      = FREQ_W + FACT_W;
  localparam int CAP_W      = 16;

  // Divider step counter
  localparam int STEP_W     = $clog2(RATE_W);

  // Stream payload widths
  localparam int OUT_FIELDS = FREQ_W + RPM_W + 1;
  localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [RATE_W-1:0]   RST_TICK_RATE = RATE_W'(1000000);
  localparam logic [FREQ_W-1:0]   RST_MIN_FREQ  = FREQ_W'(1);
  localparam logic [FREQ_W-1:0]   RST_MAX_FREQ  = FREQ_W'(1000);
  localparam logic [OVF_BITS-1:0] RST_OVF_LIMIT = OVF_BITS'(100);
  localparam logic [FACT_W-1:0]   RST_RPM_PER_HZ = FACT_W'(20);

  // Event kinds carried in tuser
  localparam logic CMD_EDGE     = 1'b0;
  localparam logic CMD_OVERFLOW = 1'b1;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TICK_RATE  = 3'd0,
    REG_MIN_FREQ   = 3'd1,
    REG_MAX_FREQ   = 3'd2,
    REG_OVF_LIMIT  = 3'd3,
    REG_RPM_PER_HZ = 3'd4
  } cfg_reg_t;

endpackage

@@ rtl/tach_period_to_frequency_top.sv @@
// Tachometer frequency meter: capture pairing, bit-serial divider and result register.
//
// Usage
//   Requests arrive on the s_ stream: tuser gives the kind (capture edge or
//   counter overflow), tdata the 16-bit capture value. Every request returns
//   one result on the m_ stream: frequency in hertz, speed (frequency times
//   rpm_per_hz) and the measuring flag.
//   The first edge arms the block; overflows while armed are counted; the
//   closing edge forms the tick count and, if it is nonzero, divides tick_rate by it.
//   The user must write the registers through cfg_wen/cfg_addr/cfg_wdata
//   only while idle; the block itself does not enforce this.
// Request flow
//   An overflow, an arming edge or a zero-count closing edge goes from ST_IDLE to
//   ST_DONE, which loads the result; a closing edge with a nonzero tick count first
//   runs the restoring divider (one quotient bit per cycle over the 24-bit tick rate)
//   and the limit check. One request is in flight at a time; s_tready is high only when idle.
// Reset and stall
//   rst (synchronous) restores the register defaults, disarms the block and
//   clears the frequency. A stalled receiver holds the result in the output
//   register; one further request may be taken meanwhile, and its result
//   waits until the held one has gone.
module tach_period_to_frequency_top (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration writes
  input  logic                         cfg_wen,
  input  logic [tpf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Event stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [tpf_pkg::CAP_W-1:0]    s_tdata,   // [15:0] capture_value
  input  logic                         s_tuser,   // [0] cmd
  // Result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tpf_pkg::OUT_W-1:0]    m_tdata    // [15:0] freq_hz, [39:16] rpm,
                                                  // [40] measuring, [47:41] zero
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Configuration registers
  logic [tpf_pkg::RATE_W-1:0]   tick_rate;
  logic [tpf_pkg::FREQ_W-1:0]   min_freq;
  logic [tpf_pkg::FREQ_W-1:0]   max_freq;
  logic [tpf_pkg::OVF_BITS-1:0] overflow_limit;
  logic [tpf_pkg::FACT_W-1:0]   rpm_per_hz;

  // Measurement state
  state_t                       state;
  logic                         armed;
  logic [tpf_pkg::CNT_BITS-1:0] first_capture;
  logic [tpf_pkg::OVF_BITS-1:0] overflow_count;
  logic [tpf_pkg::FREQ_W-1:0]   frequency;

  // Divider datapath
  logic [tpf_pkg::TICK_W-1:0]   divisor;
  logic [tpf_pkg::TICK_W-1:0]   remainder;
  logic [tpf_pkg::RATE_W-1:0]   quotient;
  logic [tpf_pkg::STEP_W-1:0]   step;

  logic                         in_accept;
  logic [tpf_pkg::CNT_BITS-1:0] cap_diff;
  logic [tpf_pkg::TICK_W-1:0]   ticks;
  logic [tpf_pkg::OVF_BITS:0]   ovf_next;
  logic [tpf_pkg::TICK_W:0]     rem_shift;
  logic                         rem_fits;
  logic                         freq_ok;
  logic                         out_free;
  logic [tpf_pkg::RPM_W-1:0]    rpm_next;

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Tick count: a wrapped difference covers both the plain and the wrapped case
  assign cap_diff = s_tdata[tpf_pkg::CNT_BITS-1:0] - first_capture;
  assign ticks    = {overflow_count, cap_diff};
  assign ovf_next = {1'b0, overflow_count} + (tpf_pkg::OVF_BITS+1)'(1);

  // One restoring division step
  assign rem_shift = {remainder, quotient[tpf_pkg::RATE_W-1]};
  assign rem_fits  = (rem_shift >= {1'b0, divisor});

  // Limit check on the full quotient
  assign freq_ok = (quotient >= tpf_pkg::RATE_W'(min_freq)) &&
                   (quotient <= tpf_pkg::RATE_W'(max_freq));

  assign rpm_next = frequency * rpm_per_hz;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate      <= tpf_pkg::RST_TICK_RATE;
      min_freq       <= tpf_pkg::RST_MIN_FREQ;
      max_freq       <= tpf_pkg::RST_MAX_FREQ;
      overflow_limit <= tpf_pkg::RST_OVF_LIMIT;
      rpm_per_hz     <= tpf_pkg::RST_RPM_PER_HZ;
    end else if (cfg_wen) begin
      case (tpf_pkg::cfg_reg_t'(cfg_addr))
        tpf_pkg::REG_TICK_RATE:  tick_rate      <= cfg_wdata[tpf_pkg::RATE_W-1:0];
        tpf_pkg::REG_MIN_FREQ:   min_freq       <= cfg_wdata[tpf_pkg::FREQ_W-1:0];
        tpf_pkg::REG_MAX_FREQ:   max_freq       <= cfg_wdata[tpf_pkg::FREQ_W-1:0];
        tpf_pkg::REG_OVF_LIMIT:  overflow_limit <= cfg_wdata[tpf_pkg::OVF_BITS-1:0];
        tpf_pkg::REG_RPM_PER_HZ: rpm_per_hz     <= cfg_wdata[tpf_pkg::FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence a request: pair captures, count overflows, divide, check limits, load the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      armed          <= 1'b0;
      first_capture  <= '0;
      overflow_count <= '0;
      frequency      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the held result is taken
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_DONE;
            if (s_tuser == tpf_pkg::CMD_OVERFLOW) begin
              // Count overflows while armed; time out past the limit
              if (armed) begin
                if (ovf_next > {1'b0, overflow_limit}) begin
                  frequency <= '0;
                  armed     <= 1'b0;
                end else begin
                  overflow_count <= ovf_next[tpf_pkg::OVF_BITS-1:0];
                end
              end
            end else if (!armed) begin
              first_capture  <= s_tdata[tpf_pkg::CNT_BITS-1:0];
              overflow_count <= '0;
              armed          <= 1'b1;
            end else begin
              // Closing edge: start the divider unless the count is zero
              armed <= 1'b0;
              if (ticks != '0) begin
                divisor   <= ticks;
                remainder <= '0;
                quotient  <= tick_rate;
                step      <= tpf_pkg::STEP_W'(tpf_pkg::RATE_W - 1);
                state     <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (rem_fits) begin
            remainder <= tpf_pkg::TICK_W'(rem_shift - {1'b0, divisor});
          end else begin
            remainder <= rem_shift[tpf_pkg::TICK_W-1:0];
          end
          quotient <= {quotient[tpf_pkg::RATE_W-2:0], rem_fits};
          step     <= step - tpf_pkg::STEP_W'(1);
          if (step == '0) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          frequency <= freq_ok ? quotient[tpf_pkg::FREQ_W-1:0] : '0;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata  <= {(tpf_pkg::OUT_W - tpf_pkg::OUT_FIELDS)'(0),
                         armed, rpm_next, frequency};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The divider only runs after a closing edge has disarmed the block
  a_div_disarmed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !armed)
    else $error("divider running while armed");

  // A finished request with a free output register yields a result next cycle
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not loaded from done state");

  // A measured frequency lies within the limits or is zero
  a_freq_limits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=>
      (frequency == '0 || (frequency >= min_freq && frequency <= max_freq)))
    else $error("frequency outside limits");

  // A closing edge with a nonzero count starts the divider
  a_edge_divides: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == tpf_pkg::CMD_EDGE && armed && ticks != '0)
      |=> (state == ST_DIV))
    else $error("closing edge did not start the divider");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the tachometer period-to-frequency meter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register index outside the defined list; writes to it must be ignored
  localparam logic [tpf_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic [tpf_pkg::FREQ_W-1:0] freq_hz;
    logic [tpf_pkg::RPM_W-1:0]  rpm;
    logic                       measuring;
  } reading_t;

  // Tracks the meter's registers and state, and the readings still owed
  class speed_scoreboard;
    logic [tpf_pkg::RATE_W-1:0]   tick_rate;
    logic [tpf_pkg::FREQ_W-1:0]   min_freq;
    logic [tpf_pkg::FREQ_W-1:0]   max_freq;
    logic [tpf_pkg::OVF_BITS-1:0] ovf_limit;
    logic [tpf_pkg::FACT_W-1:0]   rpm_factor;
    logic                         armed;
    logic [tpf_pkg::CNT_BITS-1:0] first_cap;
    logic [tpf_pkg::OVF_BITS-1:0] ovf_cnt;
    logic [tpf_pkg::FREQ_W-1:0]   freq;
    reading_t                     readings_due[$];
    int                           errors;

    function new();
      tick_rate  = tpf_pkg::RST_TICK_RATE;
      min_freq   = tpf_pkg::RST_MIN_FREQ;
      max_freq   = tpf_pkg::RST_MAX_FREQ;
      ovf_limit  = tpf_pkg::RST_OVF_LIMIT;
      rpm_factor = tpf_pkg::RST_RPM_PER_HZ;
      armed      = 1'b0;
      first_cap  = '0;
      ovf_cnt    = '0;
      freq       = '0;
      errors     = 0;
    endfunction

    // Mirror a register write, truncated to the register width
    function void set_reg(logic [tpf_pkg::CFG_ADDR_W-1:0] idx,
                          logic [tpf_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        tpf_pkg::REG_TICK_RATE:  tick_rate  = val[tpf_pkg::RATE_W-1:0];
        tpf_pkg::REG_MIN_FREQ:   min_freq   = val[tpf_pkg::FREQ_W-1:0];
        tpf_pkg::REG_MAX_FREQ:   max_freq   = val[tpf_pkg::FREQ_W-1:0];
        tpf_pkg::REG_OVF_LIMIT:  ovf_limit  = val[tpf_pkg::OVF_BITS-1:0];
        tpf_pkg::REG_RPM_PER_HZ: rpm_factor = val[tpf_pkg::FACT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the state for one accepted request and queue the reading it owes
    function void note_event(logic cmd, logic [tpf_pkg::CAP_W-1:0] value);
      longint unsigned span, a, b, n, ticks, quot, rate;
      int              nxt;
      reading_t        r;
      span = 64'd1 << tpf_pkg::CNT_BITS;
      if (cmd == tpf_pkg::CMD_EDGE) begin
        if (!armed) begin
          first_cap = value[tpf_pkg::CNT_BITS-1:0];
          ovf_cnt   = '0;
          armed     = 1'b1;
        end else begin
          a = first_cap;
          b = value[tpf_pkg::CNT_BITS-1:0];
          n = ovf_cnt;
          // A wrapped second value costs one extra counter period
          if (b >= a)
            ticks = n * span + (b - a);
          else
            ticks = (n + 1) * span - (a - b);
          // A zero span leaves the frequency as it was
          if (ticks != 0) begin
            rate = tick_rate;
            quot = rate / ticks;
            if (quot >= min_freq && quot <= max_freq)
              freq = quot[tpf_pkg::FREQ_W-1:0];
            else
              freq = '0;
          end
          armed = 1'b0;
        end
      end else if (armed) begin
        // Time out once the overflow count would pass the limit
        nxt = int'(ovf_cnt) + 1;
        if (nxt > int'(ovf_limit)) begin
          freq  = '0;
          armed = 1'b0;
        end else begin
          ovf_cnt = nxt[tpf_pkg::OVF_BITS-1:0];
        end
      end
      r.freq_hz   = freq;
      r.rpm       = tpf_pkg::RPM_W'(freq) * tpf_pkg::RPM_W'(rpm_factor);
      r.measuring = armed;
      readings_due.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Compare one delivered reading with the oldest one owed
    task check_reading(logic [tpf_pkg::OUT_W-1:0] word);
      reading_t want;
      logic [tpf_pkg::FREQ_W-1:0] got_freq;
      logic [tpf_pkg::RPM_W-1:0]  got_rpm;
      logic                       got_meas;
      got_freq = word[tpf_pkg::FREQ_W-1:0];
      got_rpm  = word[tpf_pkg::FREQ_W +: tpf_pkg::RPM_W];
      got_meas = word[tpf_pkg::FREQ_W + tpf_pkg::RPM_W];
      if (readings_due.size() == 0) begin
        report_mismatch("reading with none owed, freq_hz", got_freq, 0);
      end else begin
        want = readings_due.pop_front();
        if (got_freq !== want.freq_hz)
          report_mismatch("freq_hz", got_freq, want.freq_hz);
        if (got_rpm !== want.rpm)
          report_mismatch("rpm", got_rpm, want.rpm);
        if (got_meas !== want.measuring)
          report_mismatch("measuring", got_meas, want.measuring);
      end
    endtask

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_wen   = 1'b0;
  logic [tpf_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [tpf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [tpf_pkg::CAP_W-1:0]      s_tdata   = '0;   // [15:0] capture_value
  logic                           s_tuser   = 1'b0; // [0] cmd
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [tpf_pkg::OUT_W-1:0]      m_tdata;  // [15:0] freq_hz, [39:16] rpm, [40] measuring

  speed_scoreboard sb;
  int events_sent = 0;
  int send_idle   = 25;
  int recv_idle   = 75;

  tach_period_to_frequency_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  // Stall the result side at random and check each reading taken
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        sb.check_reading(m_tdata);
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold until taken
  task send_event(logic cmd, logic [tpf_pkg::CAP_W-1:0] value);
    if (events_sent < 250) begin
      send_idle = 25;
      recv_idle = 75;
    end else if (events_sent < 500) begin
      send_idle = 75;
      recv_idle = 25;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(cmd, value);
    events_sent++;
  endtask

  task send_overflows(int count);
    for (int i = 0; i < count; i++)
      send_event(tpf_pkg::CMD_OVERFLOW, tpf_pkg::CAP_W'($urandom));
  endtask

  // Hold off new requests until every owed reading has come back
  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_reg(logic [tpf_pkg::CFG_ADDR_W-1:0] idx, logic [tpf_pkg::CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // One measurement: mostly a clean edge/overflows/edge run, sometimes noise
  task run_measurement();
    int pick, n;
    logic [tpf_pkg::CAP_W-1:0] a, b;
    pick = $urandom_range(0, 99);
    a = tpf_pkg::CAP_W'($urandom);
    b = ($urandom_range(0, 9) == 0) ? a : tpf_pkg::CAP_W'($urandom);
    if (pick < 12) begin
      send_event(tpf_pkg::CMD_OVERFLOW & 1'($urandom), tpf_pkg::CAP_W'($urandom));
    end else if (pick < 20) begin
      // Arm and leave the measurement open
      send_event(tpf_pkg::CMD_EDGE, a);
      send_overflows($urandom_range(0, 3));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        n = $urandom_range(0, 2);
      else if (pick < 85)
        n = $urandom_range(3, 20);
      else if (sb.ovf_limit <= 20)
        n = int'(sb.ovf_limit) - 1 + $urandom_range(0, 2);
      else
        n = $urandom_range(0, 2);
      send_event(tpf_pkg::CMD_EDGE, a);
      send_overflows(n);
      send_event(tpf_pkg::CMD_EDGE, b);
    end
  endtask

  task run_phase(logic [tpf_pkg::CFG_DATA_W-1:0] rate, logic [tpf_pkg::CFG_DATA_W-1:0] lo,
                 logic [tpf_pkg::CFG_DATA_W-1:0] hi, logic [tpf_pkg::CFG_DATA_W-1:0] limit,
                 logic [tpf_pkg::CFG_DATA_W-1:0] factor, int count);
    int start;
    drain();
    write_reg(tpf_pkg::REG_TICK_RATE, rate);
    write_reg(tpf_pkg::REG_MIN_FREQ, lo);
    write_reg(tpf_pkg::REG_MAX_FREQ, hi);
    write_reg(tpf_pkg::REG_OVF_LIMIT, limit);
    write_reg(tpf_pkg::REG_RPM_PER_HZ, factor);
    start = events_sent;
    while (events_sent - start < count) run_measurement();
  endtask

  initial begin
    int lo;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: disarmed overflow, zero span, wrapped value, band edges
    send_event(tpf_pkg::CMD_OVERFLOW, 16'hFFFF);
    send_event(tpf_pkg::CMD_EDGE, 16'h0000);
    send_event(tpf_pkg::CMD_EDGE, 16'h0000);
    send_event(tpf_pkg::CMD_EDGE, 16'hFFFF);
    send_event(tpf_pkg::CMD_OVERFLOW, 16'h0000);
    send_event(tpf_pkg::CMD_EDGE, 16'h0000);
    send_event(tpf_pkg::CMD_EDGE, 16'd1000);
    send_event(tpf_pkg::CMD_EDGE, 16'd2000);
    send_event(tpf_pkg::CMD_EDGE, 16'h5555);
    send_event(tpf_pkg::CMD_EDGE, 16'h5555);
    send_event(tpf_pkg::CMD_EDGE, 16'd0);
    send_event(tpf_pkg::CMD_EDGE, 16'd999);

    // Directed: overflow timeout and a zero tick rate
    drain();
    write_reg(tpf_pkg::REG_OVF_LIMIT, 24'd1);
    write_reg(tpf_pkg::REG_TICK_RATE, 24'd0);
    write_reg(tpf_pkg::REG_MIN_FREQ, 24'd0);
    write_reg(REG_SPARE, 24'hFFFFFF);
    send_event(tpf_pkg::CMD_EDGE, 16'h00FF);
    send_event(tpf_pkg::CMD_OVERFLOW, 16'h0000);
    send_event(tpf_pkg::CMD_OVERFLOW, 16'h0000);
    send_event(tpf_pkg::CMD_OVERFLOW, 16'h0000);
    send_event(tpf_pkg::CMD_EDGE, 16'd10);
    send_event(tpf_pkg::CMD_EDGE, 16'd20);

    // Directed: inverted band, upper write bits must be dropped
    drain();
    write_reg(tpf_pkg::REG_TICK_RATE, 24'd1000000);
    write_reg(tpf_pkg::REG_MIN_FREQ, 24'hFF01F4);
    write_reg(tpf_pkg::REG_MAX_FREQ, 24'hAB0064);
    send_event(tpf_pkg::CMD_EDGE, 16'd0);
    send_event(tpf_pkg::CMD_EDGE, 16'd2000);

    // Random runs across register settings: defaults, extremes, random values, an inverted band
    run_phase(24'd1000000, 24'd1, 24'd1000, 24'd100, 24'd20, 55);
    run_phase(24'hFFFFFF, 24'd0, 24'd65535, 24'd3, 24'd255, 55);
    run_phase(24'd1, 24'd0, 24'd65535, 24'd255, 24'd1, 45);
    // A full limit still times out on the overflow that would pass 255
    send_event(tpf_pkg::CMD_EDGE, 16'h1234);
    send_overflows(257);
    send_event(tpf_pkg::CMD_EDGE, 16'h1233);
    lo = $urandom_range(0, 200);
    run_phase(24'($urandom_range(1, 24'hFFFFFF)), 24'(lo),
              24'($urandom_range(lo, 65535)), 24'($urandom_range(1, 20)),
              24'($urandom_range(1, 255)), 55);
    run_phase(24'hFFFFFF, 24'd65535, 24'd0, 24'd255, 24'd128, 25);
    lo = $urandom_range(0, 50);
    run_phase(24'($urandom_range(1, 2000000)), 24'(lo),
              24'($urandom_range(lo, 5000)), 24'($urandom_range(1, 255)),
              24'($urandom_range(1, 255)), 55);

    // Let the last readings out, then settle
    drain();
    repeat (30) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch("readings never delivered", 0, sb.pending());
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
